FILE: rtl/core/lcr_pkg.sv
`default_nettype none

package lcr_pkg;

  // Number of line-start entries held in the table.
  localparam int unsigned TABLE_DEPTH = 4096;

  // Table index width, and the width of a count that can hold the depth itself.
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  // Widths of the transaction fields.
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LINE_W   = 13;
  localparam int unsigned COLUMN_W = 33;

  // Input function codes.
  localparam logic FUNC_APPEND  = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage : lcr_pkg

`default_nettype wire

FILE: rtl/core/lcr_ram.sv
`default_nettype none

module lcr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : lcr_ram

`default_nettype wire

FILE: rtl/core/line_column_resolver_top.sv
`default_nettype none

// Channel  Direction  Handshake        Payload
// in_      input      in_valid/stall   in_func, in_offset
// out_     output     out_valid/stall  out_line, out_column, out_status
//
// An append goes from acceptance through ST_FINISH into the output register; a resolve
// first runs k binary-search steps (at most ADDR_W + 1, so 13 at a depth of 4096),
// each paced by one registered read of the line-start RAM. The input reopens in the
// same cycle that the result is offered, so no new item is taken before that.
// Reset sets the entry count to one and idles the pipeline; the RAM is not cleared,
// entry 0 being read as zero. One result may wait on out_stall while the next is found.

module line_column_resolver_top
  import lcr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_func,
  input  wire logic [OFFSET_W-1:0] in_offset,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [LINE_W-1:0]   out_line,
  output logic      [COLUMN_W-1:0] out_column,
  output logic                     out_status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // Table fill level; always at least one since entry 0 is fixed at zero.
  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;

  // Search registers: the live window [low, high], the midpoint whose data
  // the RAM returns this cycle, and the best entry accepted so far.
  logic [CNT_W-1:0]    low_r, low_nxt;
  logic [CNT_W-1:0]    high_r, high_nxt;
  logic [ADDR_W-1:0]   mid_r, mid_nxt;
  logic [ADDR_W-1:0]   best_r, best_nxt;
  logic [OFFSET_W-1:0] best_val_r, best_val_nxt;
  logic [OFFSET_W-1:0] key_r, key_nxt;

  // Result held until the output register is free.
  logic [LINE_W-1:0]   res_line_r, res_line_nxt;
  logic [COLUMN_W-1:0] res_column_r, res_column_nxt;
  logic                res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0]   out_line_r, out_line_nxt;
  logic [COLUMN_W-1:0] out_column_r, out_column_nxt;
  logic                out_status_r, out_status_nxt;

  // RAM port signals.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [OFFSET_W-1:0] ram_rdata;
  logic [OFFSET_W-1:0] entry_val;

  // Search helpers.
  logic                in_accept;
  logic                table_full;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    mid_wide;
  logic                search_done;

  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign table_full = (entry_count_r == CNT_W'(TABLE_DEPTH));

  // Entry 0 is never written by an append, so it is supplied here.
  assign entry_val = (mid_r == '0) ? '0 : ram_rdata;

  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    low_nxt         = low_r;
    high_nxt        = high_r;
    best_nxt        = best_r;
    best_val_nxt    = best_val_r;
    key_nxt         = key_r;
    res_line_nxt    = res_line_r;
    res_column_nxt  = res_column_r;
    res_status_nxt  = res_status_r;
    ram_we          = 1'b0;
    ram_waddr       = entry_count_r[ADDR_W-1:0];
    search_done     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_func == FUNC_APPEND) begin
            res_line_nxt   = '0;
            res_column_nxt = '0;
            if (table_full) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              res_status_nxt  = STATUS_OK;
              ram_we          = 1'b1;
              entry_count_nxt = entry_count_r + 1'b1;
            end
            state_nxt = ST_FINISH;
          end else begin
            // The opening window is never empty, as the count is at least one.
            key_nxt      = in_offset;
            low_nxt      = '0;
            high_nxt     = entry_count_r - 1'b1;
            best_nxt     = '0;
            best_val_nxt = '0;
            state_nxt    = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (entry_val <= key_r) begin
          best_nxt     = mid_r;
          best_val_nxt = entry_val;
          low_nxt      = {1'b0, mid_r} + 1'b1;
        end else if (mid_r == '0) begin
          search_done = 1'b1;
        end else begin
          high_nxt = {1'b0, mid_r} - 1'b1;
        end
        if (low_nxt > high_nxt) begin
          search_done = 1'b1;
        end
        if (search_done) begin
          res_line_nxt   = LINE_W'(best_nxt) + 1'b1;
          res_column_nxt = {1'b0, key_r - best_val_nxt} + 1'b1;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Midpoint of the next window, floor of the halved span. It is valid
    // whenever a search step follows.
    span     = high_nxt - low_nxt;
    mid_wide = low_nxt + (span >> 1);
    mid_nxt  = mid_wide[ADDR_W-1:0];
  end

  // Output register: loaded from the held result, cleared when taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_line_nxt   = out_line_r;
    out_column_nxt = out_column_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FINISH && (!out_valid_r || !out_stall)) begin
      out_valid_nxt  = 1'b1;
      out_line_nxt   = res_line_r;
      out_column_nxt = res_column_r;
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= CNT_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    mid_r        <= mid_nxt;
    best_r       <= best_nxt;
    best_val_r   <= best_val_nxt;
    key_r        <= key_nxt;
    res_line_r   <= res_line_nxt;
    res_column_r <= res_column_nxt;
    res_status_r <= res_status_nxt;
    out_line_r   <= out_line_nxt;
    out_column_r <= out_column_nxt;
    out_status_r <= out_status_nxt;
  end

  // The read address is the next midpoint, so its data arrives with mid_r.
  lcr_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (TABLE_DEPTH)
  ) u_line_starts (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_offset),
    .rd_addr (mid_nxt),
    .rd_data (ram_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_line   = out_line_r;
  assign out_column = out_column_r;
  assign out_status = out_status_r;

endmodule : line_column_resolver_top

`default_nettype wire

FILE: rtl/core/lcr_checker.sv
`default_nettype none

module lcr_checker
  import lcr_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [LINE_W-1:0]   out_line,
  input wire logic [COLUMN_W-1:0] out_column,
  input wire logic                out_status
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line) && $stable(out_column)
      && $stable(out_status))
    else $error("stalled result transaction changed");

  // A dropped append carries no line and no column.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_line == '0 && out_column == '0)
    else $error("full status with non-zero position");

  // A resolve gives both line and column from one, an append gives neither.
  a_line_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_line == '0) == (out_column == '0)))
    else $error("line and column disagree on transaction kind");

  // Reset leaves no result on offer and the input open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

endmodule : lcr_checker

bind line_column_resolver_top lcr_checker u_lcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_line   (out_line),
  .out_column (out_column),
  .out_status (out_status)
);

`default_nettype wire
